### sv/sidc_pkg.sv
// Package with shared types and constants for the signed integer to decimal text converter.
package sidc_pkg;

  localparam int MAG_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = 5;
  localparam int NDIG_W     = 4;
  localparam int CHAR_W     = 7;

  localparam logic [CHAR_W-1:0]  CODE_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CODE_MINUS = 7'd45;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic dbl;
    logic dsh;
  } cell_ctrl_t;

endpackage

### sv/sidc_cell.sv
// One BCD digit cell: add-3 and shift for conversion, digit shift for output.
module sidc_cell (
  input  logic                          clk,
  input  sidc_pkg::cell_ctrl_t          ctrl,
  input  logic                          carry_in,
  input  logic [sidc_pkg::DIGIT_W-1:0]  digit_in,
  output logic                          carry_out,
  output logic [sidc_pkg::DIGIT_W-1:0]  digit
);

  logic [sidc_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    if (digit >= sidc_pkg::ADJ_LIMIT) begin
      adj = digit + sidc_pkg::ADJ_ADD;
    end else begin
      adj = digit;
    end
  end

  assign carry_out = adj[sidc_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.dbl) begin
      digit <= {adj[sidc_pkg::DIGIT_W-2:0], carry_in};
    end else if (ctrl.dsh) begin
      digit <= digit_in;
    end
  end

endmodule

### sv/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Steps: accept, a double-dabble conversion pass across the ten cells, a leading-zero skip,
// then one character per cycle while the output is not stalled (sign plus 1 to 10 digits)
// through an output register. A new value is accepted only after the last character of
// the previous one has been loaded into the output register.
// Reset: rst is synchronous, active high; clears the sequencer and output valid.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero fill
  output logic        m_axis_tlast    // last_char
);

  localparam int ND = sidc_pkg::NUM_DIGITS;
  localparam int DW = sidc_pkg::DIGIT_W;

  sidc_pkg::state_t            state, state_next;
  sidc_pkg::cell_ctrl_t        ctrl;
  logic [sidc_pkg::MAG_W-1:0]  mag;
  logic [sidc_pkg::CNT_W-1:0]  cnt;
  logic [sidc_pkg::NDIG_W-1:0] ndig;
  logic                        neg;
  logic [sidc_pkg::CHAR_W-1:0] out_char;
  logic                        out_valid;
  logic                        out_last;

  logic                        in_fire;
  logic                        out_free;
  logic                        conv_done;
  logic                        top_zero;
  logic                        load_sign;
  logic                        load_digit;

  logic [DW-1:0]               dig   [ND];
  logic [DW-1:0]               dlow  [ND];
  logic                        carry [ND+1];

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid || m_axis_tready;
  assign conv_done  = (cnt == sidc_pkg::CNT_W'(sidc_pkg::MAG_W - 1));
  assign top_zero   = (dig[ND-1] == '0) && (ndig != sidc_pkg::NDIG_W'(1));
  assign carry[0]   = mag[sidc_pkg::MAG_W-1];

  genvar g;
  generate
    for (g = 0; g < ND; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign dlow[g] = '0;
      end else begin : g_rest
        assign dlow[g] = dig[g-1];
      end
      sidc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .carry_in (carry[g]),
        .digit_in (dlow[g]),
        .carry_out(carry[g+1]),
        .digit    (dig[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      sidc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = sidc_pkg::ST_CONV;
        end
      end
      sidc_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = sidc_pkg::ST_SKIP;
        end
      end
      sidc_pkg::ST_SKIP: begin
        if (!top_zero) begin
          state_next = neg ? sidc_pkg::ST_SIGN : sidc_pkg::ST_EMIT;
        end
      end
      sidc_pkg::ST_SIGN: begin
        if (out_free) begin
          state_next = sidc_pkg::ST_EMIT;
        end
      end
      sidc_pkg::ST_EMIT: begin
        if (out_free && ndig == sidc_pkg::NDIG_W'(1)) begin
          state_next = sidc_pkg::ST_IDLE;
        end
      end
      default: state_next = sidc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    load_sign     = 1'b0;
    load_digit    = 1'b0;
    case (state)
      sidc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.clr      = s_axis_tvalid;
      end
      sidc_pkg::ST_CONV: begin
        ctrl.dbl = 1'b1;
      end
      sidc_pkg::ST_SKIP: begin
        ctrl.dsh = top_zero;
      end
      sidc_pkg::ST_SIGN: begin
        load_sign = out_free;
      end
      sidc_pkg::ST_EMIT: begin
        load_digit = out_free;
        ctrl.dsh   = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sidc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sign || load_digit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg  <= s_axis_tdata[31];
      mag  <= s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
      cnt  <= '0;
      ndig <= sidc_pkg::NDIG_W'(ND);
    end else if (ctrl.dbl) begin
      mag <= {mag[sidc_pkg::MAG_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end else if (ctrl.dsh) begin
      ndig <= ndig - 1'b1;
    end
    if (load_sign) begin
      out_char <= sidc_pkg::CODE_MINUS;
      out_last <= 1'b0;
    end else if (load_digit) begin
      out_char <= sidc_pkg::CODE_ZERO + {{(sidc_pkg::CHAR_W-DW){1'b0}}, dig[ND-1]};
      out_last <= (ndig == sidc_pkg::NDIG_W'(1));
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};
  assign m_axis_tlast  = out_last;

endmodule

### sv/sidc_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
module sidc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == 8'd45) ||
      (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57))
    else $error("output beat is not a sign or digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata == 8'd45 |-> !m_axis_tlast)
    else $error("minus sign marked as last beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again during conversion");

endmodule

bind signed_int_to_decimal_ascii sidc_checker u_sidc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

### dv/tb.sv
// Testbench for the signed integer to decimal ASCII converter, checked against a built-in predictor.
`timescale 1ns / 100ps

module tb;

  localparam int          RAND_ITEMS  = 290;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 60;
  localparam logic [31:0] DEC_BASE    = 32'd10;

  typedef struct {
    logic [sidc_pkg::CHAR_W-1:0] code;
    logic                        last;
  } ascii_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic [31:0] pending_values [$];
  ascii_beat_t expected_chars [$];
  int          char_errors = 0;
  int          src_gap = 0;
  int          src_calm = 0;
  int          sink_gap = 0;
  int          sink_calm = 0;
  int          stall_cycles = 0;

  signed_int_to_decimal_ascii u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 3) begin
      calm = $urandom_range(40, 15);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void queue_decimal_text(input logic [31:0] value);
    logic [31:0]                  mag;
    logic [sidc_pkg::DIGIT_W-1:0] digit [sidc_pkg::NUM_DIGITS];
    int                           n;
    ascii_beat_t                  beat;
    n = 0;
    mag = value[31] ? (~value + 32'd1) : value;
    do begin
      digit[n] = sidc_pkg::DIGIT_W'(mag % DEC_BASE);
      mag = mag / DEC_BASE;
      n++;
    end while (mag != 0 && n < sidc_pkg::NUM_DIGITS);
    if (value[31]) begin
      beat.code = sidc_pkg::CODE_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int i = n - 1; i >= 0; i--) begin
      beat.code = sidc_pkg::CODE_ZERO + sidc_pkg::CHAR_W'(digit[i]);
      beat.last = (i == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) queue_decimal_text(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_values.size() > 0) begin
          s_axis_tdata  <= pending_values.pop_front();
          s_axis_tvalid <= 1'b1;
          src_gap = idle_len(src_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ascii_beat_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          char_errors++;
          if (char_errors <= 10)
            $display("unexpected beat: code %0d last %0b",
                     m_axis_tdata[sidc_pkg::CHAR_W-1:0], m_axis_tlast);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata[sidc_pkg::CHAR_W-1:0] !== want.code ||
              m_axis_tlast !== want.last) begin
            char_errors++;
            if (char_errors <= 10)
              $display("mismatch: expected code %0d last %0b, got code %0d last %0b",
                       want.code, want.last, m_axis_tdata[sidc_pkg::CHAR_W-1:0],
                       m_axis_tlast);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap = idle_len(sink_calm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic wait_all_delivered();
    @(negedge clk);
    while (pending_values.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    longint p10 [11];
    longint mag;
    longint lo;
    longint hi;
    bit     neg;
    int     pick;
    int     nd;
    p10[0] = 1;
    for (int i = 1; i < 11; i++) p10[i] = p10[i-1] * 10;

    pending_values = '{32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
                       32'd100, 32'd12345, -32'd12345, 32'd999999999, 32'd1000000000,
                       -32'd1000000000, 32'd1234567890, -32'd1234567890, 32'h7FFF_FFFF,
                       32'h8000_0001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // hold the source until the directed text has drained
    wait_all_delivered();

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) wait_all_delivered();
      pick = $urandom_range(99, 0);
      neg  = $urandom_range(1, 0);
      if (pick < 30) begin
        pending_values.push_back($urandom);
      end else if (pick < 80) begin
        nd = $urandom_range(10, 1);
        lo = (nd == 1) ? 0 : p10[nd-1];
        hi = p10[nd] - 1;
        if (hi > 64'd2147483647 + neg) hi = 64'd2147483647 + neg;
        mag = lo + longint'($urandom % 32'(hi - lo + 1));
        pending_values.push_back(neg ? 32'(-mag) : 32'(mag));
      end else begin
        mag = p10[$urandom_range(9, 0)] + $urandom_range(2, 0) - 1;
        pending_values.push_back(neg ? 32'(-mag) : 32'(mag));
      end
    end

    wait_all_delivered();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (char_errors == 0 && expected_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
sv/sidc_pkg.sv
sv/sidc_cell.sv
sv/signed_int_to_decimal_ascii.sv
sv/sidc_checker.sv
dv/tb.sv
